>>> rtl/core/lzw_compressor_assert.svh
// assertion macros used by the lzw compressor datapath
`ifndef LZW_COMPRESSOR_ASSERT_SVH
`define LZW_COMPRESSOR_ASSERT_SVH

// condition holds at every clock edge out of reset
`define LZW_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define LZW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/lzw_pkg.sv
// shared types and constants of the lzw compressor
package lzw_pkg;

  localparam int DictEntriesDef  = 4096;
  localparam int AlphabetSizeDef = 26;
  localparam int LetterW         = 5;
  localparam int CodeOutW        = 12;

  typedef enum logic [2:0] {
    StIdle,
    StDecide,
    StScan,
    StCompare,
    StMiss,
    StEmitLast
  } lzw_state_e;

  typedef struct packed {
    logic latch_in;
    logic set_prefix_letter;
    logic set_prefix_hit;
    logic set_valid;
    logic clear_valid;
    logic scan_start;
    logic scan_next;
    logic emit;
    logic emit_last;
    logic dict_write;
  } lzw_cmd_t;

  typedef struct packed {
    logic out_of_range;
    logic eom;
    logic prefix_valid;
    logic dict_empty;
    logic dict_full;
    logic hit;
    logic scan_last;
    logic out_free;
  } lzw_status_t;

endpackage

>>> rtl/core/lzw_compressor.sv
// top level of the lzw compressor
// LZW encoder: one letter beat (0..AlphabetSize-1, end_of_message on the last
// letter of a message) goes in, zero to two code beats come out. The dictionary
// lookup is a linear scan of the learned entries through a memory with
// registered read; each entry is read in StScan and compared in StCompare. The
// first letter of a message only sets the prefix, a hit extends the prefix to
// the matching entry, and a miss emits the prefix code and learns a new entry.
// The final code of a message is emitted in StEmitLast. Each emitted code also
// waits while a full output register is held by a stalled code beat. The
// dictionary holds its entries across messages and stops learning when full.
// No clearing pass is needed after reset.
module lzw_compressor import lzw_pkg::*; #(
  parameter int DictEntries  = DictEntriesDef,
  parameter int AlphabetSize = AlphabetSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // letter channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [LetterW-1:0]  letter_i,
  input  logic                end_of_message_i,
  // code channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CodeOutW-1:0] code_o,
  output logic                last_code_o
);

  lzw_cmd_t    cmd;
  lzw_status_t status;

  // sequencer: decide, scan, emit
  lzw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // prefix state, dictionary and output register
  lzw_datapath #(
    .DictEntries  (DictEntries),
    .AlphabetSize (AlphabetSize)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .letter_i         (letter_i),
    .end_of_message_i (end_of_message_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .code_o           (code_o),
    .last_code_o      (last_code_o)
  );

endmodule

>>> rtl/core/lzw_ctrl.sv
// control state machine of the lzw compressor
module lzw_ctrl import lzw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lzw_status_t status_i,
  output lzw_cmd_t    cmd_o
);

  lzw_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = StDecide;
        end
      end
      StDecide: begin
        if (status_i.out_of_range) begin
          state_d = (status_i.eom && status_i.prefix_valid) ? StEmitLast : StIdle;
        end else if (!status_i.prefix_valid) begin
          cmd_o.set_prefix_letter = 1'b1;
          cmd_o.set_valid         = 1'b1;
          state_d = status_i.eom ? StEmitLast : StIdle;
        end else if (status_i.dict_empty) begin
          state_d = StMiss;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = StScan;
        end
      end
      StScan: begin
        state_d = StCompare;
      end
      StCompare: begin
        if (status_i.hit) begin
          cmd_o.set_prefix_hit = 1'b1;
          state_d = status_i.eom ? StEmitLast : StIdle;
        end else if (status_i.scan_last) begin
          state_d = StMiss;
        end else begin
          cmd_o.scan_next = 1'b1;
          state_d         = StScan;
        end
      end
      StMiss: begin
        if (status_i.out_free) begin
          cmd_o.emit              = 1'b1;
          cmd_o.dict_write        = !status_i.dict_full;
          cmd_o.set_prefix_letter = 1'b1;
          state_d = status_i.eom ? StEmitLast : StIdle;
        end
      end
      StEmitLast: begin
        if (status_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.clear_valid = 1'b1;
          state_d           = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

>>> rtl/core/lzw_datapath.sv
// prefix, dictionary memory, scan counter and output register of the lzw compressor
`include "lzw_compressor_assert.svh"
module lzw_datapath import lzw_pkg::*; #(
  parameter int DictEntries  = DictEntriesDef,
  parameter int AlphabetSize = AlphabetSizeDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [LetterW-1:0]  letter_i,
  input  logic                end_of_message_i,
  input  lzw_cmd_t            cmd_i,
  output lzw_status_t         status_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CodeOutW-1:0] code_o,
  output logic                last_code_o
);

  localparam int CodeW  = $clog2(DictEntries);
  localparam int CntW   = $clog2(DictEntries + 1);
  localparam int EntryW = CodeW + LetterW;

  logic [LetterW-1:0] letter_q;
  logic               eom_q;
  logic [CodeW-1:0]   prefix_q;
  logic               prefix_valid_q;
  logic [CntW-1:0]    count_q;
  logic [CodeW-1:0]   scan_idx_q;
  logic [EntryW-1:0]  rdata_q;
  logic [EntryW-1:0]  mem [DictEntries];
  logic               out_valid_q;
  logic [CodeW-1:0]   out_code_q;
  logic               out_last_q;
  logic [31:0]        out_code_wide;
  logic [CntW-1:0]    scan_idx_ext;

  assign scan_idx_ext = CntW'(scan_idx_q);

  // input beat latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      letter_q <= letter_i;
      eom_q    <= end_of_message_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_q       <= '0;
      prefix_valid_q <= 1'b0;
      count_q        <= CntW'(AlphabetSize);
    end else begin
      if (cmd_i.set_prefix_letter) begin
        prefix_q <= CodeW'(letter_q);
      end else if (cmd_i.set_prefix_hit) begin
        prefix_q <= scan_idx_q;
      end
      if (cmd_i.set_valid) begin
        prefix_valid_q <= 1'b1;
      end else if (cmd_i.clear_valid) begin
        prefix_valid_q <= 1'b0;
      end
      if (cmd_i.dict_write) begin
        count_q <= count_q + CntW'(1);
      end
    end
  end

  // linear scan index
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_start) begin
      scan_idx_q <= CodeW'(AlphabetSize);
    end else if (cmd_i.scan_next) begin
      scan_idx_q <= scan_idx_q + CodeW'(1);
    end
  end

  // dictionary memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.dict_write) begin
      mem[count_q[CodeW-1:0]] <= {prefix_q, letter_q};
    end
    rdata_q <= mem[scan_idx_q];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_code_q <= prefix_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign out_code_wide = 32'(out_code_q);
  assign out_valid_o   = out_valid_q;
  assign code_o        = out_code_wide[CodeOutW-1:0];
  assign last_code_o   = out_last_q;

  always_comb begin
    status_o.out_of_range = (9'(letter_q) >= 9'(AlphabetSize));
    status_o.eom          = eom_q;
    status_o.prefix_valid = prefix_valid_q;
    status_o.dict_empty   = (count_q == CntW'(AlphabetSize));
    status_o.dict_full    = (count_q == CntW'(DictEntries));
    status_o.hit          = (rdata_q == {prefix_q, letter_q});
    status_o.scan_last    = ((scan_idx_ext + CntW'(1)) == count_q);
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

  `LZW_ASSERT(a_count_bound, count_q <= CntW'(DictEntries), "entry count past dictionary size")
  `LZW_ASSERT(a_no_overwrite, !(cmd_i.emit && out_valid_q && out_stall_i), "result overwritten")
  `LZW_ASSERT_NEXT(a_count_step, !cmd_i.dict_write, $stable(count_q), "count moved without write")

endmodule
